@@ rtl/lpr_pkg.sv @@
// lpr_pkg: shared widths, reset values and control structs for the lru page replacement block
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package lpr_pkg;

    localparam int PAGE_NUMBER_W   = 16;
    localparam int FRAME_COUNT_W   = 5;
    localparam int FRAME_INDEX_W   = 4;
    localparam int TOTAL_W         = 32;
    localparam int FRAMES_DEFAULT  = 16;
    localparam int PAGE_BITS_DEF   = 16;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = FRAME_COUNT_W'(16);

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_issue;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/lpr_in_if.sv @@
// lpr_in_if: page reference channel, valid/ready handshake
// depends on lpr_pkg
`default_nettype none

interface lpr_in_if;
    import lpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PAGE_NUMBER_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

`default_nettype wire

@@ rtl/lpr_out_if.sv @@
// lpr_out_if: result channel, valid/ready handshake
// depends on lpr_pkg
`default_nettype none

interface lpr_out_if;
    import lpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic                     filled_empty;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic [TOTAL_W-1:0]       fault_count;
    logic [TOTAL_W-1:0]       hit_count;

    modport source (output valid, output hit, output filled_empty, output frame_index,
                    output fault_count, output hit_count, input ready);
    modport sink   (input valid, input hit, input filled_empty, input frame_index,
                    input fault_count, input hit_count, output ready);
endinterface

`default_nettype wire

@@ rtl/lpr_dp.sv @@
// lpr_dp: frame page memory, valid and recency ranks, scan accumulators, totals, result register
// depends on lpr_pkg; driven by lpr_ctrl through t_dp_cmd / t_dp_sts
`default_nettype none

module lpr_dp #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lpr_pkg::FRAME_COUNT_W-1:0] i_cfg_wdata,
    input  wire logic [lpr_pkg::PAGE_NUMBER_W-1:0] i_page_number,
    input  wire lpr_pkg::t_dp_cmd                  i_cmd,
    output lpr_pkg::t_dp_sts                       o_sts,
    output logic                                   o_hit,
    output logic                                   o_filled_empty,
    output logic [lpr_pkg::FRAME_INDEX_W-1:0]      o_frame_index,
    output logic [lpr_pkg::TOTAL_W-1:0]            o_fault_count,
    output logic [lpr_pkg::TOTAL_W-1:0]            o_hit_count
);
    import lpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int RW = IW;

    logic [FRAME_COUNT_W-1:0] r_frame_count;
    logic [CW-1:0]            r_n;
    logic [CW-1:0]            n_n;
    logic [PAGE_BITS-1:0]     r_page;

    logic [PAGE_BITS-1:0]     r_mem [FRAMES];
    logic [PAGE_BITS-1:0]     r_rd_data;
    logic [FRAMES-1:0]        r_valid;
    logic [RW-1:0]            r_rank [FRAMES];

    logic [CW-1:0]            r_rd_idx;
    logic                     r_cmp_vld;
    logic [IW-1:0]            r_cmp_idx;

    logic                     r_hit;
    logic [IW-1:0]            r_hit_idx;
    logic [RW-1:0]            r_hit_rank;
    logic                     r_emp;
    logic [IW-1:0]            r_emp_idx;
    logic [IW-1:0]            r_min_idx;
    logic [RW-1:0]            r_min_rank;
    logic [CW-1:0]            r_vcnt;

    logic [TOTAL_W-1:0]       r_fault_total;
    logic [TOTAL_W-1:0]       r_hit_total;
    logic [TOTAL_W-1:0]       n_fault_total;
    logic [TOTAL_W-1:0]       n_hit_total;

    logic                     r_out_hit;
    logic                     r_out_filled;
    logic [FRAME_INDEX_W-1:0] r_out_index;
    logic [TOTAL_W-1:0]       r_out_fault;
    logic [TOTAL_W-1:0]       r_out_hits;

    logic                     cmp_valid;
    logic [RW-1:0]            cmp_rank;
    logic [IW-1:0]            sel_idx;
    logic                     old_valid;
    logic [RW-1:0]            old_rank;
    logic [RW-1:0]            new_rank;

    // frames in use, clamped to 1..FRAMES
    always_comb begin
        if (r_frame_count == '0) begin
            n_n = CW'(1);
        end else if (int'(r_frame_count) > FRAMES) begin
            n_n = CW'(FRAMES);
        end else begin
            n_n = CW'(r_frame_count);
        end
    end

    assign o_sts.last_issue = (r_rd_idx == (r_n - CW'(1)));

    assign cmp_valid = r_valid[r_cmp_idx];
    assign cmp_rank  = r_rank[r_cmp_idx];

    always_comb begin
        if (r_hit) begin
            sel_idx   = r_hit_idx;
            old_valid = 1'b1;
            old_rank  = r_hit_rank;
        end else if (r_emp) begin
            sel_idx   = r_emp_idx;
            old_valid = 1'b0;
            old_rank  = r_min_rank;
        end else begin
            sel_idx   = r_min_idx;
            old_valid = 1'b1;
            old_rank  = r_min_rank;
        end
        new_rank = RW'(r_vcnt - CW'(old_valid));
    end

    assign n_hit_total   = (r_hit && (r_hit_total != '1)) ? r_hit_total + TOTAL_W'(1)
                                                          : r_hit_total;
    assign n_fault_total = (!r_hit && (r_fault_total != '1)) ? r_fault_total + TOTAL_W'(1)
                                                             : r_fault_total;

    // page memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[sel_idx] <= r_page;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    // scan pointer and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= CW'(1);
            r_page     <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_idx  <= '0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_hit_rank <= '0;
            r_emp      <= 1'b0;
            r_emp_idx  <= '0;
            r_min_idx  <= '0;
            r_min_rank <= '0;
            r_vcnt     <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.issue) begin
                r_cmp_idx <= r_rd_idx[IW-1:0];
                r_rd_idx  <= r_rd_idx + CW'(1);
            end
            if (i_cmd.start) begin
                r_n      <= n_n;
                r_page   <= PAGE_BITS'(i_page_number);
                r_rd_idx <= '0;
                r_hit    <= 1'b0;
                r_emp    <= 1'b0;
                r_vcnt   <= '0;
            end else if (r_cmp_vld) begin
                if (cmp_valid && (r_rd_data == r_page) && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_rank <= cmp_rank;
                end
                if (!cmp_valid && !r_emp) begin
                    r_emp     <= 1'b1;
                    r_emp_idx <= r_cmp_idx;
                end
                if ((r_cmp_idx == '0) || (cmp_rank < r_min_rank)) begin
                    r_min_idx  <= r_cmp_idx;
                    r_min_rank <= cmp_rank;
                end
                r_vcnt <= r_vcnt + CW'(cmp_valid);
            end
        end
    end

    // frame state update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_fault_total <= '0;
            r_hit_total   <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_valid[sel_idx] <= 1'b1;
            r_fault_total    <= n_fault_total;
            r_hit_total      <= n_hit_total;
            for (int i = 0; i < FRAMES; i++) begin
                if (IW'(i) == sel_idx) begin
                    r_rank[i] <= new_rank;
                end else if ((CW'(i) < r_n) && r_valid[i] && old_valid &&
                             (r_rank[i] > old_rank)) begin
                    r_rank[i] <= r_rank[i] - RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit    <= r_hit;
            r_out_filled <= !r_hit && r_emp;
            r_out_index  <= FRAME_INDEX_W'(sel_idx);
            r_out_fault  <= n_fault_total;
            r_out_hits   <= n_hit_total;
        end
    end

    assign o_hit          = r_out_hit;
    assign o_filled_empty = r_out_filled;
    assign o_frame_index  = r_out_index;
    assign o_fault_count  = r_out_fault;
    assign o_hit_count    = r_out_hits;

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (r_rd_idx < r_n))
        else $error("frame scan beyond frames in use");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_valid[$past(sel_idx)] == 1'b1))
        else $error("committed frame not marked valid");

    a_one_total_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (($past(r_fault_total) == r_fault_total) ||
                          ($past(r_hit_total) == r_hit_total)))
        else $error("fault and hit totals both changed");

endmodule

`default_nettype wire

@@ rtl/lpr_ctrl.sv @@
// lpr_ctrl: sequencer for one page reference: accept, frame scan, commit, result handoff
// depends on lpr_pkg; commands lpr_dp through t_dp_cmd / t_dp_sts
`default_nettype none

module lpr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output lpr_pkg::t_dp_cmd      o_cmd,
    input  wire lpr_pkg::t_dp_sts i_sts
);
    import lpr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_scan_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_SCAN))
        else $error("scan did not follow an accepted transaction");

    a_commit_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("commit did not present a result");

    a_wait_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |=> (r_state == ST_COMMIT))
        else $error("compare drain not followed by commit");

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement.sv @@
// Fully associative page frame set with least-recently-used replacement. Each page reference
// on the input channel gives one result: hit, whether an empty frame was filled, the frame
// that now holds the page, and saturating fault and hit totals. Each reference is scanned over
// the frames in use (frame_count clamped to 1..FRAMES); the scan reads one frame page entry
// per cycle from the single read port of the frame memory. A new reference is accepted only
// after the previous one has been committed. The result sits in an output register, so the
// next reference is accepted while it waits. Reset empties all frames and clears the totals;
// reset again after changing frame_count.
// depends on lpr_pkg, lpr_in_if, lpr_out_if, lpr_ctrl, lpr_dp
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lpr_pkg::FRAME_COUNT_W-1:0] i_cfg_wdata,
    lpr_in_if.sink                                 i_in,
    lpr_out_if.source                              o_out
);
    import lpr_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    lpr_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_page_number  (i_in.page_number),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_hit          (o_out.hit),
        .o_filled_empty (o_out.filled_empty),
        .o_frame_index  (o_out.frame_index),
        .o_fault_count  (o_out.fault_count),
        .o_hit_count    (o_out.hit_count)
    );

endmodule

`default_nettype wire

@@ sim/tb_lru_page_replacement.sv @@
// tb_lru_page_replacement: self-checking bench for the lru page replacement block
// predicts every result with its own frame/recency model; directed table first, then random phases
// depends on lpr_pkg, lpr_in_if, lpr_out_if and lru_page_replacement
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lpr_pkg::*;

    localparam int NUM_FRAMES   = FRAMES_DEFAULT;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int POOL_MAX     = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                     hit;
        logic                     filled_empty;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic [TOTAL_W-1:0]       fault_count;
        logic [TOTAL_W-1:0]       hit_count;
    } t_ref_result;

    typedef enum logic {ROW_REF, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [PAGE_NUMBER_W-1:0] value;
        logic                     typed;
        t_ref_result              res;
    } t_dir_row;

    typedef struct packed {
        logic        typed;
        t_ref_result res;
    } t_dir_check;

    localparam t_ref_result NO_RES = '0;

    localparam t_dir_row DIR_TAB [28] = '{
        '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 1'b1, 4'd0, 32'd1, 32'd0}},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 4'd1, 32'd2, 32'd0}},
        '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 1'b0, 4'd0, 32'd2, 32'd1}},
        '{ROW_REF, 16'h8000, 1'b0, NO_RES},
        '{ROW_REF, 16'h7FFF, 1'b0, NO_RES},
        // shrink to two frames without reset
        '{ROW_CFG, 16'd2,    1'b0, NO_RES},
        '{ROW_REF, 16'h1234, 1'b0, NO_RES},
        '{ROW_REF, 16'h8000, 1'b0, NO_RES},
        '{ROW_REF, 16'h7FFF, 1'b0, NO_RES},
        // zero acts as one frame
        '{ROW_CFG, 16'd0,    1'b0, NO_RES},
        '{ROW_REF, 16'h00AA, 1'b0, NO_RES},
        '{ROW_REF, 16'h00AA, 1'b0, NO_RES},
        '{ROW_REF, 16'h5555, 1'b0, NO_RES},
        // above the built count acts as all frames
        '{ROW_CFG, 16'd31,   1'b0, NO_RES},
        '{ROW_REF, 16'h8000, 1'b0, NO_RES},
        '{ROW_REF, 16'h0001, 1'b0, NO_RES},
        '{ROW_REF, 16'h0002, 1'b0, NO_RES},
        '{ROW_REF, 16'h0004, 1'b0, NO_RES},
        '{ROW_REF, 16'h0008, 1'b0, NO_RES},
        '{ROW_REF, 16'h0010, 1'b0, NO_RES},
        '{ROW_REF, 16'h0020, 1'b0, NO_RES},
        '{ROW_REF, 16'h0040, 1'b0, NO_RES},
        '{ROW_REF, 16'h0080, 1'b0, NO_RES},
        '{ROW_REF, 16'h0100, 1'b0, NO_RES},
        '{ROW_REF, 16'h0200, 1'b0, NO_RES},
        '{ROW_REF, 16'h0400, 1'b0, NO_RES},
        '{ROW_REF, 16'h0800, 1'b0, NO_RES},
        '{ROW_REF, 16'h1000, 1'b0, NO_RES}
    };

    localparam logic [FRAME_COUNT_W-1:0] PHASE_CFG [PHASES] =
        '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd7, 5'd11, 5'd16};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [FRAME_COUNT_W-1:0] i_cfg_wdata;

    lpr_in_if  in_ch ();
    lpr_out_if out_ch ();

    lru_page_replacement uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state
    logic [PAGE_NUMBER_W-1:0] page_tab  [NUM_FRAMES];
    bit                       valid_tab [NUM_FRAMES];
    logic [3:0]               rank_tab  [NUM_FRAMES];
    logic [TOTAL_W-1:0]       fault_tot = '0;
    logic [TOTAL_W-1:0]       hit_tot   = '0;
    logic [FRAME_COUNT_W-1:0] frame_count_q = FRAME_COUNT_RST;

    t_ref_result lru_expect_q [$];
    t_dir_check  dir_check_q  [$];

    int  err_count   = 0;
    int  sent_count  = 0;
    int  res_count   = 0;
    int  cycle_count = 0;
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    bit  hold_armed = 0;
    bit  hold_taken = 0;
    int  hold_left  = 0;

    logic [PAGE_NUMBER_W-1:0] page_pool [POOL_MAX];

    function automatic int clamp_frames(input logic [FRAME_COUNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > NUM_FRAMES) return NUM_FRAMES;
        return int'(v);
    endfunction

    function automatic t_ref_result lru_access(input logic [PAGE_NUMBER_W-1:0] page);
        int          n;
        int          f;
        bit          found;
        bit          filled;
        logic [3:0]  others;
        t_ref_result r;
        n = clamp_frames(frame_count_q);
        f = 0;
        found = 0;
        filled = 0;
        for (int i = 0; i < n; i++) begin
            if (!found && valid_tab[i] && page_tab[i] == page) begin
                found = 1;
                f = i;
            end
        end
        if (found) begin
            if (hit_tot != '1) hit_tot = hit_tot + 1;
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!filled && !valid_tab[i]) begin
                    filled = 1;
                    f = i;
                end
            end
            if (!filled) begin
                f = 0;
                for (int i = 1; i < n; i++)
                    if (rank_tab[i] < rank_tab[f]) f = i;
            end
            if (fault_tot != '1) fault_tot = fault_tot + 1;
        end
        // touched frame becomes most recent, newer frames move down one rank
        others = '0;
        for (int i = 0; i < n; i++) begin
            if (i == f || !valid_tab[i]) continue;
            if (valid_tab[f] && rank_tab[i] > rank_tab[f]) rank_tab[i] = rank_tab[i] - 4'd1;
            others = others + 4'd1;
        end
        valid_tab[f] = 1;
        rank_tab[f]  = others;
        page_tab[f]  = page;
        r.hit          = found;
        r.filled_empty = filled;
        r.frame_index  = f[FRAME_INDEX_W-1:0];
        r.fault_count  = fault_tot;
        r.hit_count    = hit_tot;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            page_tab[i]  = '0;
            valid_tab[i] = 0;
            rank_tab[i]  = '0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_page_replacement verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken <= 1;
            hold_left  <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: results first, then any register write and the new transaction
    always @(posedge i_clk) begin : monitor
        t_ref_result want;
        t_ref_result pred;
        t_dir_check  chk;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                res_count++;
                if (lru_expect_q.size() == 0) begin
                    $error("unexpected result transaction, frame_index %0d", out_ch.frame_index);
                    err_count++;
                end else begin
                    want = lru_expect_q.pop_front();
                    compare_field("hit", want.hit, out_ch.hit);
                    compare_field("filled_empty", want.filled_empty, out_ch.filled_empty);
                    compare_field("frame_index", want.frame_index, out_ch.frame_index);
                    compare_field("fault_count", want.fault_count, out_ch.fault_count);
                    compare_field("hit_count", want.hit_count, out_ch.hit_count);
                end
            end
            if (i_cfg_we) frame_count_q = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready) begin
                pred = lru_access(in_ch.page_number);
                chk  = dir_check_q.pop_front();
                lru_expect_q.push_back(chk.typed ? chk.res : pred);
            end
        end
    end

    task automatic send_ref(input logic [PAGE_NUMBER_W-1:0] page, input logic typed,
                            input t_ref_result res);
        t_dir_check chk;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        chk.typed = typed;
        chk.res   = res;
        dir_check_q.push_back(chk);
        in_ch.valid       <= 1'b1;
        in_ch.page_number <= page;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (res_count < sent_count) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [FRAME_COUNT_W-1:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int pool_size;
        logic [PAGE_NUMBER_W-1:0] page;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.page_number = '0;
        out_ch.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[r]) begin
            if (DIR_TAB[r].kind == ROW_CFG)
                write_frame_count(DIR_TAB[r].value[FRAME_COUNT_W-1:0]);
            else
                send_ref(DIR_TAB[r].value, DIR_TAB[r].typed, DIR_TAB[r].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_frame_count(PHASE_CFG[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
                default: begin src_idle_pct = 26; snk_stall_pct = 26; end
            endcase
            // working set of the frames in use plus up to three more pages
            pool_size = clamp_frames(PHASE_CFG[p]) + $urandom_range(3);
            if (pool_size > POOL_MAX) pool_size = POOL_MAX;
            for (int i = 0; i < POOL_MAX; i++)
                page_pool[i] = PAGE_NUMBER_W'($urandom_range(16'hFFFF));
            if (p == 4) hold_armed = 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == PHASE_ITEMS / 2) wait_drained();
                if ($urandom_range(99) < 85)
                    page = page_pool[$urandom_range(pool_size - 1)];
                else
                    page = PAGE_NUMBER_W'($urandom_range(16'hFFFF));
                send_ref(page, 1'b0, NO_RES);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lru_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", lru_expect_q.size());
            err_count++;
        end
        $display("%0d page references, %0d results checked (%0d hits, %0d faults)",
                 sent_count, res_count, hit_tot, fault_tot);
        $display("frame counts 0..31 incl. changes without reset, idle/stall mixes, long hold-off");
        if (err_count == 0)
            $display("lru_page_replacement verification clean");
        else
            $display("lru_page_replacement verification failed");
        $finish;
    end

endmodule

@@ lru_page_replacement.f @@
rtl/lpr_pkg.sv
rtl/lpr_in_if.sv
rtl/lpr_out_if.sv
rtl/lpr_dp.sv
rtl/lpr_ctrl.sv
rtl/lru_page_replacement.sv
sim/tb_lru_page_replacement.sv
